// ===== rtl/upgma_pkg.sv =====
// upgma_pkg: shared constants, command/status structs and address helper
// for the UPGMA clustering core. No dependencies.
package upgma_pkg;

  localparam int MAX_TAXA = 16;
  localparam int DIST_W   = 24;
  localparam int HGT_W    = 25;
  localparam int BR_W     = 26;
  localparam int SIZE_W   = 5;
  localparam int IDX_W    = 4;
  localparam int ADDR_W   = 8;
  localparam int CNT_W    = 9;

  // write data source codes
  localparam logic [1:0] WSRC_IN   = 2'd0;
  localparam logic [1:0] WSRC_VAL  = 2'd1;
  localparam logic [1:0] WSRC_ZERO = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wsrc;
    logic [ADDR_W-1:0] raddr;
    logic              scan_clr;
    logic              cmp_en;
    logic [IDX_W-1:0]  cmp_row;
    logic [IDX_W-1:0]  cmp_col;
    logic [IDX_W-1:0]  cl_addr;
    logic              lat_a;
    logic              lat_b;
    logic              lat_h;
    logic              mul_a;
    logic              mul_b;
    logic              div_start;
    logic              out_load;
    logic              out_nopair;
    logic              out_last;
    logic              cl_update;
    logic              cl_clear;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pair_a;
    logic [IDX_W-1:0] pair_b;
    logic             div_busy;
    logic             out_free;
  } sts_t;

  // flat matrix address row*n+col
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col,
                                                  input logic [4:0]       n);
    logic [9:0] full;
    full = ({6'd0, row} * {5'd0, n}) + {6'd0, col};
    return full[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/upgma_dp.sv =====
// upgma_dp: datapath of the UPGMA core: matrix memory, minimum search,
// cluster size/height store, serial divider and the result register.
// Depends on upgma_pkg; driven by upgma_ctrl.
module upgma_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [upgma_pkg::DIST_W-1:0]   in_distance,
  input  upgma_pkg::cmd_t                cmd,
  output upgma_pkg::sts_t                sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [upgma_pkg::IDX_W-1:0]    out_left_cluster,
  output logic [upgma_pkg::IDX_W-1:0]    out_right_cluster,
  output logic [upgma_pkg::HGT_W-1:0]    out_merge_height,
  output logic signed [upgma_pkg::BR_W-1:0] out_left_branch,
  output logic signed [upgma_pkg::BR_W-1:0] out_right_branch,
  output logic [upgma_pkg::SIZE_W-1:0]   out_merged_size,
  output logic                           out_no_pair,
  output logic                           out_last_merge
);
  import upgma_pkg::*;

  localparam int PROD_W = DIST_W + SIZE_W;
  localparam int NUM_W  = PROD_W + 1;

  logic [DIST_W-1:0] mem [MAX_TAXA*MAX_TAXA];
  logic [DIST_W-1:0] rd_data_r;
  logic [DIST_W-1:0] wdata;

  logic [DIST_W-1:0] best_v_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_row_r, best_col_r;
  logic [IDX_W-1:0]  pair_a, pair_b;
  logic              cmp_hit;

  logic [SIZE_W-1:0] sizes_r   [MAX_TAXA];
  logic [HGT_W-1:0]  heights_r [MAX_TAXA];
  logic [SIZE_W-1:0] sa_r, sb_r;
  logic [HGT_W-1:0]  ha_r, hb_r;
  logic [DIST_W-1:0] height_r;
  logic [SIZE_W:0]   tot;
  logic [SIZE_W-1:0] sum_sat;

  logic [PROD_W-1:0] prod_a_r, prod_b_r;
  logic [NUM_W-1:0]  div_num_r;
  logic [SIZE_W:0]   div_rem_r;
  logic [4:0]        div_cnt_r;
  logic [SIZE_W+1:0] rem_sh;
  logic              q_bit;
  logic [SIZE_W+1:0] rem_sub;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         left_r, right_r;
  logic [HGT_W-1:0]         mh_r;
  logic signed [BR_W-1:0]   lb_r, rb_r;
  logic [SIZE_W-1:0]        ms_r;
  logic                     np_r, last_r;

  // matrix memory, one write and one registered read per cycle
  always_comb begin
    case (cmd.wsrc)
      WSRC_IN:  wdata = in_distance;
      WSRC_VAL: wdata = div_num_r[DIST_W-1:0];
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= wdata;
    end
    rd_data_r <= mem[cmd.raddr];
  end

  // first smallest nonzero entry
  assign cmp_hit = cmd.cmp_en && (rd_data_r != '0) && (!found_r || (rd_data_r < best_v_r));
  assign pair_a  = (best_row_r < best_col_r) ? best_row_r : best_col_r;
  assign pair_b  = (best_row_r < best_col_r) ? best_col_r : best_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      found_r <= 1'b0;
    end else if (cmp_hit) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_hit) begin
      best_v_r   <= rd_data_r;
      best_row_r <= cmd.cmp_row;
      best_col_r <= cmd.cmp_col;
    end
  end

  // cluster sizes and heights
  assign tot     = {1'b0, sa_r} + {1'b0, sb_r};
  assign sum_sat = tot[SIZE_W] ? {SIZE_W{1'b1}} : tot[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cl_clear) begin
      for (int k = 0; k < MAX_TAXA; k++) begin
        sizes_r[k]   <= SIZE_W'(1);
        heights_r[k] <= '0;
      end
    end else if (cmd.cl_update) begin
      sizes_r[pair_a]   <= sum_sat;
      heights_r[pair_a] <= {1'b0, height_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_a) begin
      sa_r <= sizes_r[cmd.cl_addr];
      ha_r <= heights_r[cmd.cl_addr];
    end
    if (cmd.lat_b) begin
      sb_r <= sizes_r[cmd.cl_addr];
      hb_r <= heights_r[cmd.cl_addr];
    end
    if (cmd.lat_h) begin
      height_r <= rd_data_r;
    end
    if (cmd.mul_a) begin
      prod_a_r <= rd_data_r * sa_r;
    end
    if (cmd.mul_b) begin
      prod_b_r <= rd_data_r * sb_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {div_rem_r, div_num_r[NUM_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, tot});
  assign rem_sub = rem_sh - {1'b0, tot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= 5'(NUM_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num_r <= {1'b0, prod_a_r} + {1'b0, prod_b_r};
      div_rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      div_num_r <= {div_num_r[NUM_W-2:0], q_bit};
      div_rem_r <= q_bit ? rem_sub[SIZE_W:0] : rem_sh[SIZE_W:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      np_r   <= cmd.out_nopair;
      last_r <= cmd.out_last;
      if (cmd.out_nopair) begin
        left_r  <= '0;
        right_r <= '0;
        mh_r    <= '0;
        lb_r    <= '0;
        rb_r    <= '0;
        ms_r    <= '0;
      end else begin
        left_r  <= pair_a;
        right_r <= pair_b;
        mh_r    <= {1'b0, height_r};
        lb_r    <= $signed({2'b00, height_r} - {1'b0, ha_r});
        rb_r    <= $signed({2'b00, height_r} - {1'b0, hb_r});
        ms_r    <= sum_sat;
      end
    end
  end

  assign sts.found    = found_r;
  assign sts.pair_a   = pair_a;
  assign sts.pair_b   = pair_b;
  assign sts.div_busy = (div_cnt_r != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_left_cluster  = left_r;
  assign out_right_cluster = right_r;
  assign out_merge_height  = mh_r;
  assign out_left_branch   = lb_r;
  assign out_right_branch  = rb_r;
  assign out_merged_size   = ms_r;
  assign out_no_pair       = np_r;
  assign out_last_merge    = last_r;

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending beat");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (div_cnt_r == '0))
    else $error("divider restarted while busy");
  a_val_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.we && (cmd.wsrc == WSRC_VAL)) |-> (div_cnt_r == '0))
    else $error("average written before quotient done");

endmodule

// ===== rtl/upgma_ctrl.sv =====
// upgma_ctrl: sequencer of the UPGMA core: load counter, scan, merge-row
// loop and result issue, plus the taxa_count register. Depends on upgma_pkg.
module upgma_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [4:0]      cfg_taxa_count,
  input  upgma_pkg::sts_t sts,
  output upgma_pkg::cmd_t cmd
);
  import upgma_pkg::*;

  localparam logic [4:0] ST_LOAD  = 5'd0;
  localparam logic [4:0] ST_SCAN  = 5'd1;
  localparam logic [4:0] ST_SEND  = 5'd2;
  localparam logic [4:0] ST_PICK  = 5'd3;
  localparam logic [4:0] ST_HGT   = 5'd4;
  localparam logic [4:0] ST_RES   = 5'd5;
  localparam logic [4:0] ST_NP    = 5'd6;
  localparam logic [4:0] ST_MTEST = 5'd7;
  localparam logic [4:0] ST_RDB   = 5'd8;
  localparam logic [4:0] ST_MUL   = 5'd9;
  localparam logic [4:0] ST_DIVS  = 5'd10;
  localparam logic [4:0] ST_DIVW  = 5'd11;
  localparam logic [4:0] ST_W0    = 5'd12;
  localparam logic [4:0] ST_W1    = 5'd13;
  localparam logic [4:0] ST_W2    = 5'd14;
  localparam logic [4:0] ST_W3    = 5'd15;
  localparam logic [4:0] ST_FIN   = 5'd16;

  logic [4:0]       state_r, state_nxt;
  logic [4:0]       taxa_r;
  logic [4:0]       n_r, n_nxt;
  logic [CNT_W-1:0] load_r, load_nxt, load_inc;
  logic [7:0]       k_r, k_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic             cmp_en_r;
  logic [IDX_W-1:0] cmp_row_r, cmp_col_r;
  logic [IDX_W-1:0] rnd_r, rnd_nxt, i_r, i_nxt;
  logic             zero_r, zero_nxt;
  logic [4:0]       n_eff;
  logic [9:0]       nn_eff, nn_run;
  logic             last_round, last_i;

  // clamp taxa_count into 2..MAX_TAXA
  always_comb begin
    if (taxa_r < 5'd2) begin
      n_eff = 5'd2;
    end else if (taxa_r > 5'(MAX_TAXA)) begin
      n_eff = 5'(MAX_TAXA);
    end else begin
      n_eff = taxa_r;
    end
  end

  assign nn_eff     = {5'd0, n_eff} * {5'd0, n_eff};
  assign nn_run     = {5'd0, n_r} * {5'd0, n_r};
  assign load_inc   = load_r + 9'd1;
  assign last_round = ({1'b0, rnd_r} + 5'd2) == n_r;
  assign last_i     = {1'b0, i_r} == (n_r - 5'd1);

  assign in_ready  = (state_r == ST_LOAD);
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    n_nxt     = n_r;
    load_nxt  = load_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    rnd_nxt   = rnd_r;
    i_nxt     = i_r;
    zero_nxt  = zero_r;
    cmd.cmp_en  = cmp_en_r;
    cmd.cmp_row = cmp_row_r;
    cmd.cmp_col = cmp_col_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.we    = !load_r[CNT_W-1];
          cmd.waddr = load_r[ADDR_W-1:0];
          cmd.wsrc  = WSRC_IN;
          load_nxt  = load_inc;
          if (load_inc >= nn_eff[CNT_W-1:0]) begin
            n_nxt        = n_eff;
            k_nxt        = '0;
            row_nxt      = '0;
            col_nxt      = '0;
            rnd_nxt      = '0;
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.raddr = k_r;
        if ({2'b00, k_r} == (nn_run - 10'd1)) begin
          state_nxt = ST_SEND;
        end else begin
          k_nxt = k_r + 8'd1;
          if ({1'b0, col_r} == (n_r - 5'd1)) begin
            col_nxt = '0;
            row_nxt = row_r + 4'd1;
          end else begin
            col_nxt = col_r + 4'd1;
          end
        end
      end
      ST_SEND: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (!sts.found) begin
          state_nxt = ST_NP;
        end else begin
          cmd.raddr   = cell_addr(sts.pair_a, sts.pair_b, n_r);
          cmd.cl_addr = sts.pair_a;
          cmd.lat_a   = 1'b1;
          state_nxt   = ST_HGT;
        end
      end
      ST_HGT: begin
        cmd.lat_h   = 1'b1;
        cmd.cl_addr = sts.pair_b;
        cmd.lat_b   = 1'b1;
        state_nxt   = ST_RES;
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_last  = last_round;
          cmd.cl_update = 1'b1;
          i_nxt         = '0;
          state_nxt     = ST_MTEST;
        end
      end
      ST_NP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_nopair = 1'b1;
          cmd.out_last   = 1'b1;
          state_nxt      = ST_FIN;
        end
      end
      ST_MTEST: begin
        // cells at the pair's own columns end up cleared
        cmd.raddr = cell_addr(sts.pair_a, i_r, n_r);
        if ((i_r == sts.pair_a) || (i_r == sts.pair_b)) begin
          zero_nxt  = 1'b1;
          state_nxt = ST_W0;
        end else begin
          zero_nxt  = 1'b0;
          state_nxt = ST_RDB;
        end
      end
      ST_RDB: begin
        cmd.raddr = cell_addr(sts.pair_b, i_r, n_r);
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (!sts.div_busy) begin
          state_nxt = ST_W0;
        end
      end
      ST_W0: begin
        cmd.we    = 1'b1;
        cmd.waddr = cell_addr(sts.pair_a, i_r, n_r);
        cmd.wsrc  = zero_r ? WSRC_ZERO : WSRC_VAL;
        state_nxt = ST_W1;
      end
      ST_W1: begin
        cmd.we    = 1'b1;
        cmd.waddr = cell_addr(sts.pair_b, i_r, n_r);
        cmd.wsrc  = WSRC_ZERO;
        state_nxt = ST_W2;
      end
      ST_W2: begin
        cmd.we    = 1'b1;
        cmd.waddr = cell_addr(i_r, sts.pair_a, n_r);
        cmd.wsrc  = zero_r ? WSRC_ZERO : WSRC_VAL;
        state_nxt = ST_W3;
      end
      ST_W3: begin
        cmd.we    = 1'b1;
        cmd.waddr = cell_addr(i_r, sts.pair_b, n_r);
        cmd.wsrc  = WSRC_ZERO;
        if (last_i) begin
          if (last_round) begin
            state_nxt = ST_FIN;
          end else begin
            rnd_nxt      = rnd_r + 4'd1;
            k_nxt        = '0;
            row_nxt      = '0;
            col_nxt      = '0;
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end else begin
          i_nxt     = i_r + 4'd1;
          state_nxt = ST_MTEST;
        end
      end
      ST_FIN: begin
        cmd.cl_clear = 1'b1;
        load_nxt     = '0;
        state_nxt    = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      taxa_r   <= 5'd2;
      n_r      <= 5'd2;
      load_r   <= '0;
      cmp_en_r <= 1'b0;
      rnd_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      load_r   <= load_nxt;
      cmp_en_r <= (state_r == ST_SCAN);
      rnd_r    <= rnd_nxt;
      if (cfg_valid && cfg_ready) begin
        taxa_r <= cfg_taxa_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    i_r       <= i_nxt;
    zero_r    <= zero_nxt;
    cmp_row_r <= row_r;
    cmp_col_r <= col_r;
  end

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> (({1'b0, rnd_r} + 5'd2) <= n_r))
    else $error("merge round past n-1");
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> !load_r[CNT_W-1])
    else $error("load count past the matrix");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({2'b00, k_r} < nn_run))
    else $error("scan address past n*n");

endmodule

// ===== rtl/upgma_clustering_core.sv =====
// upgma_clustering_core: top level of the UPGMA clustering block.
// Instantiates upgma_ctrl and upgma_dp; depends on upgma_pkg.
//
//  channel | ports                          | beat
//  in      | in_valid/in_ready              | in_distance, one matrix entry
//  out     | out_valid/out_ready            | one merge result (8 fields)
//  cfg     | cfg_valid/cfg_ready            | cfg_taxa_count
//
// Entries load at one beat per cycle into a 256 x 24 matrix RAM.
// Then in_ready drops for up to n-1 rounds: an n*n scan (one read a cycle),
// a pick and the result issue, then each column of the merged row is rebuilt
// in turn (30-step serial divide, then four writes) while the pair's own
// columns are only zeroed; a closing step clears the cluster store each run.
// Reset is synchronous, no clearing pass; a stalled out channel holds the
// sequencer only when the next result is ready to issue.
module upgma_clustering_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [upgma_pkg::DIST_W-1:0]   in_distance,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [upgma_pkg::IDX_W-1:0]    out_left_cluster,
  output logic [upgma_pkg::IDX_W-1:0]    out_right_cluster,
  output logic [upgma_pkg::HGT_W-1:0]    out_merge_height,
  output logic signed [upgma_pkg::BR_W-1:0] out_left_branch,
  output logic signed [upgma_pkg::BR_W-1:0] out_right_branch,
  output logic [upgma_pkg::SIZE_W-1:0]   out_merged_size,
  output logic                           out_no_pair,
  output logic                           out_last_merge,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [4:0]                     cfg_taxa_count
);
  import upgma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  upgma_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_taxa_count (cfg_taxa_count),
    .sts            (sts),
    .cmd            (cmd)
  );

  upgma_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_distance       (in_distance),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_cluster  (out_left_cluster),
    .out_right_cluster (out_right_cluster),
    .out_merge_height  (out_merge_height),
    .out_left_branch   (out_left_branch),
    .out_right_branch  (out_right_branch),
    .out_merged_size   (out_merged_size),
    .out_no_pair       (out_no_pair),
    .out_last_merge    (out_last_merge)
  );

endmodule

// ===== tb/tb_upgma_clustering_core.sv =====
// Self-checking testbench for upgma_clustering_core: loads distance matrices and checks
// every merge result against an in-bench UPGMA predictor. Depends on upgma_pkg and the RTL.
`timescale 1ns / 100ps

module tb_upgma_clustering_core;
  import upgma_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 3000;
  localparam int ITEM_TARGET = 350;

  typedef struct packed {
    logic [IDX_W-1:0]  left_idx;
    logic [IDX_W-1:0]  right_idx;
    logic [HGT_W-1:0]  height;
    logic [BR_W-1:0]   left_br;
    logic [BR_W-1:0]   right_br;
    logic [SIZE_W-1:0] size;
    logic              no_pair;
    logic              last;
  } merge_res_t;

  typedef struct {
    bit                is_cfg;
    logic [4:0]        cfg_val;
    logic [DIST_W-1:0] dist_val;
    bit                typed;
    merge_res_t        want;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [DIST_W-1:0] in_distance = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [IDX_W-1:0] out_left_cluster, out_right_cluster;
  logic [HGT_W-1:0] out_merge_height;
  logic signed [BR_W-1:0] out_left_branch, out_right_branch;
  logic [SIZE_W-1:0] out_merged_size;
  logic out_no_pair, out_last_merge;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [4:0] cfg_taxa_count = 5'd2;

  always #10 clk = ~clk;

  upgma_clustering_core DUT (.*);

  // predictor state
  logic [DIST_W-1:0] dmat [MAX_TAXA*MAX_TAXA];
  logic [SIZE_W-1:0] csize [MAX_TAXA];
  logic [HGT_W-1:0]  cheight [MAX_TAXA];
  int unsigned       fill_count = 0;
  logic [4:0]        taxa_reg = 5'd2;

  merge_res_t pending_merges[$];
  logic [DIST_W-1:0] matrix_q[$];
  int  error_count = 0;
  int  entries_sent = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;
  bit  rx_hold = 0;

  function automatic void reset_clusters();
    for (int k = 0; k < MAX_TAXA; k++) begin
      csize[k] = SIZE_W'(1);
      cheight[k] = '0;
    end
  endfunction

  function automatic int active_taxa();
    int n;
    n = taxa_reg;
    if (n < 2) n = 2;
    if (n > MAX_TAXA) n = MAX_TAXA;
    return n;
  endfunction

  // fold higher row/column b into a, weighted by cluster size; in-place order matters
  function automatic void fold_rows(int n, int a, int b, longint unsigned sa,
                                    longint unsigned sb);
    longint unsigned tot, num;
    logic [DIST_W-1:0] v;
    tot = sa + sb;
    if (tot == 0) tot = 1;
    for (int i = 0; i < n; i++) begin
      num = longint'(dmat[a*n+i]) * sa + longint'(dmat[b*n+i]) * sb;
      v = DIST_W'(num / tot);
      dmat[a*n+i] = v;
      dmat[b*n+i] = '0;
      dmat[i*n+a] = v;
      dmat[i*n+b] = '0;
    end
    dmat[a*n+a] = '0;
    dmat[a*n+b] = '0;
    dmat[b*n+a] = '0;
    dmat[b*n+b] = '0;
  endfunction

  // run all merges of a loaded matrix, queueing the expected results
  function automatic void cluster_matrix(int n);
    int best, a, b, t;
    logic [DIST_W-1:0] bestv;
    bit found;
    merge_res_t r;
    int unsigned sum;
    for (int rnd = 0; rnd + 1 < n; rnd++) begin
      found = 0; best = 0; bestv = '0;
      for (int k = 0; k < n*n; k++)
        if (dmat[k] != 0 && (!found || dmat[k] < bestv)) begin
          found = 1; bestv = dmat[k]; best = k;
        end
      r = '0;
      if (!found) begin
        r.no_pair = 1; r.last = 1;
        pending_merges.push_back(r);
        return;
      end
      a = best / n; b = best % n;
      if (a > b) begin t = a; a = b; b = t; end
      r.left_idx = IDX_W'(a); r.right_idx = IDX_W'(b);
      r.height = {1'b0, dmat[a*n+b]};
      sum = csize[a] + csize[b];
      if (sum > 31) sum = 31;
      r.left_br = {1'b0, r.height} - {1'b0, cheight[a]};
      r.right_br = {1'b0, r.height} - {1'b0, cheight[b]};
      r.size = SIZE_W'(sum);
      r.last = (rnd + 2 == n);
      pending_merges.push_back(r);
      fold_rows(n, a, b, csize[a], csize[b]);
      csize[a] = SIZE_W'(sum);
      cheight[a] = r.height;
    end
  endfunction

  function automatic void absorb_entry(logic [DIST_W-1:0] d);
    int n;
    n = active_taxa();
    if (fill_count < MAX_TAXA*MAX_TAXA) dmat[fill_count] = d;
    fill_count = (fill_count + 1) & 9'h1FF;
    if (fill_count < n*n) return;
    cluster_matrix(n);
    fill_count = 0;
    reset_clusters();
  endfunction

  // one input beat; leaves in_valid high so back-to-back beats need no toggle
  task automatic send_entry(logic [DIST_W-1:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_distance <= d;
    do @(posedge clk); while (!in_ready);
    entries_sent++;
    absorb_entry(d);
  endtask

  // sender pause until all results are back and the block is idle again
  task automatic drain();
    in_valid <= 0;
    while (pending_merges.size() != 0 || !in_ready) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_taxa(logic [4:0] v);
    drain();
    cfg_valid <= 1;
    cfg_taxa_count <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    taxa_reg = v;
  endtask

  // random matrix: mostly well-formed (symmetric, zero diagonal), rest noise
  task automatic build_matrix(int n);
    bit noisy, tiny;
    logic [DIST_W-1:0] v;
    matrix_q.delete();
    noisy = ($urandom_range(0, 3) == 0);
    tiny = 1'($urandom_range(0, 1));
    for (int k = 0; k < n*n; k++) matrix_q.push_back('0);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if (noisy) begin
          case ($urandom_range(0, 4))
            0: v = '0;
            1: v = '1;
            2: v = DIST_W'($urandom_range(1, 8));
            default: v = DIST_W'($urandom);
          endcase
          matrix_q[i*n+j] = v;
        end else if (j > i) begin
          v = tiny ? DIST_W'($urandom_range(1, 20)) : DIST_W'($urandom_range(1, 24'hFFFFFF));
          matrix_q[i*n+j] = v;
          matrix_q[j*n+i] = v;
        end
      end
  endtask

  // result channel: random stalls, plus a long hold on request
  initial begin
    int w;
    @(posedge clk);
    wait (rst_n);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 13);
      if (w > 0 || rx_hold) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req && !rx_hold) begin
      rx_hold <= 1;
      hold_req <= 0;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 0;
    end
  end

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    merge_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_merges.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual left=%0d right=%0d",
                 $time, out_left_cluster, out_right_cluster);
        error_count++;
      end else begin
        e = pending_merges.pop_front();
        check_field("left_cluster", e.left_idx, out_left_cluster);
        check_field("right_cluster", e.right_idx, out_right_cluster);
        check_field("merge_height", e.height, out_merge_height);
        check_field("left_branch", e.left_br, $unsigned(out_left_branch));
        check_field("right_branch", e.right_br, $unsigned(out_right_branch));
        check_field("merged_size", e.size, out_merged_size);
        check_field("no_pair", e.no_pair, out_no_pair);
        check_field("last_merge", e.last, out_last_merge);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    int idle_cycles;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic stim_row_t row_d(logic [DIST_W-1:0] d);
    stim_row_t s;
    s = '{default: '0};
    s.dist_val = d;
    return s;
  endfunction

  function automatic stim_row_t row_t(logic [DIST_W-1:0] d, merge_res_t w);
    stim_row_t s;
    s = row_d(d);
    s.typed = 1;
    s.want = w;
    return s;
  endfunction

  function automatic stim_row_t row_c(logic [4:0] v);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1;
    s.cfg_val = v;
    return s;
  endfunction

  initial begin
    stim_row_t directed[$];
    int n, mat_idx, cv;
    reset_clusters();
    for (int k = 0; k < MAX_TAXA*MAX_TAXA; k++) dmat[k] = '0;

    // 2x2 at reset width: empty matrix, diagonal pick, extremes, asymmetric zero pick
    directed = '{row_d(0), row_d(0), row_d(0),
                 row_t(0, '{0, 0, 0, 0, 0, 0, 1, 1}),
                 row_d(24'hFFFFFF), row_d(0), row_d(0),
                 row_t(0, '{0, 0, 25'hFFFFFF, 26'hFFFFFF, 26'hFFFFFF, 2, 0, 1}),
                 row_d(0), row_d(1), row_d(24'hFFFFFF),
                 row_t(0, '{0, 1, 25'd1, 26'd1, 26'd1, 2, 0, 1}),
                 row_d(0), row_d(0), row_d(5),
                 row_t(0, '{0, 1, 0, 0, 0, 2, 0, 1}),
                 row_c(3),
                 row_d(0), row_d(10), row_d(10),
                 row_d(10), row_d(0), row_d(30),
                 row_d(10), row_d(30), row_d(0)};

    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_taxa(directed[i].cfg_val);
      end else begin
        send_entry(directed[i].dist_val);
        if (directed[i].typed) begin
          void'(pending_merges.pop_back());
          pending_merges.push_back(directed[i].want);
        end
      end
    end
    drain();

    // random matrices; matrix 4 follows the held matrix 3 with no pause,
    // so its entries back up behind the stalled results
    mat_idx = 0;
    while (entries_sent < ITEM_TARGET) begin
      if (mat_idx == 5) begin
        write_taxa(5'd31);
      end else if (mat_idx == 1) begin
        write_taxa(5'd0);
      end else if (mat_idx == 2) begin
        write_taxa(5'd1);
      end else if (mat_idx == 3) begin
        write_taxa(5'd4);
      end else if (mat_idx != 4 && $urandom_range(0, 1) == 0) begin
        cv = $urandom_range(2, 6);
        write_taxa(5'(cv));
      end
      no_idle = ($urandom_range(0, 4) == 0);
      if (mat_idx == 3) hold_req = 1;
      n = active_taxa();
      build_matrix(n);
      foreach (matrix_q[k]) send_entry(matrix_q[k]);
      if (mat_idx == 5) write_taxa(5'd3);
      mat_idx++;
    end
    no_idle = 0;
    in_valid <= 0;

    while (pending_merges.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_merges.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
